FILE: hdl/mbfs_pkg.sv
// ----------------------------------------------------------------------------
// mbfs_pkg: motor bus frame sequencer package
// Codes shared by the sequencer and its port checker, plus the result layout
// and the frame checksum that only the sequencer uses.
// ----------------------------------------------------------------------------
`default_nettype none

package mbfs_pkg;

  // bus status of the previous transfer
  localparam logic [1:0] StatusSuccess = 2'd0;
  localparam logic [1:0] StatusDone    = 2'd1;
  localparam logic [1:0] StatusFailed  = 2'd2;
  localparam logic [1:0] StatusBusy    = 2'd3;

  // command codes, also used for the pending command
  localparam logic [1:0] CmdNone    = 2'd0;
  localparam logic [1:0] CmdTest    = 2'd1;
  localparam logic [1:0] CmdReverse = 2'd2;
  localparam logic [1:0] CmdSetAddr = 2'd3;

  // transfer kinds
  localparam logic [1:0] XferNone  = 2'd0;
  localparam logic [1:0] XferWrite = 2'd1;
  localparam logic [1:0] XferRead  = 2'd2;

  // address assignment steps
  localparam logic [2:0] StepReadLow      = 3'd0;
  localparam logic [2:0] StepCheckLow     = 3'd1;
  localparam logic [2:0] StepReadHigh     = 3'd2;
  localparam logic [2:0] StepCheckHigh    = 3'd3;
  localparam logic [2:0] StepWriteAddress = 3'd4;

  localparam logic [7:0]  SpeedTrailer = 8'hC0;
  localparam logic [15:0] CrcSeed      = 16'h00FF;
  localparam logic [7:0]  TestOpcode   = 8'd251;
  localparam logic [7:0]  TestBase     = 8'd231;
  localparam logic [7:0]  RevOpcode    = 8'd254;
  localparam logic [7:0]  RevBase      = 8'd234;
  localparam logic [7:0]  AddrOpcode   = 8'd252;
  localparam logic [6:0]  ReadAddrBase = 7'h06;
  localparam logic [6:0]  WriteAddr    = 7'h00;
  localparam logic [2:0]  LenSpeed     = 3'd6;
  localparam logic [2:0]  LenShort     = 3'd4;
  localparam logic [2:0]  LenRead      = 3'd3;
  localparam logic [7:0]  SerialLowTag  = 8'd2;
  localparam logic [7:0]  SerialHighTag = 8'd3;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 80;

  typedef struct packed {
    logic [1:0]  transfer_kind;
    logic [6:0]  bus_address;
    logic [2:0]  transfer_length;
    logic [7:0]  frame_byte0;
    logic [7:0]  frame_byte1;
    logic [7:0]  frame_byte2;
    logic [7:0]  frame_byte3;
    logic [7:0]  frame_byte4;
    logic [7:0]  frame_byte5;
    logic [15:0] error_count;
  } result_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] d);
    logic [7:0] x;
    x = d ^ crc[7:0];
    x = x ^ {x[3:0], 4'b0000};
    return {x, crc[15:8]} ^ {12'h000, x[7:4]} ^ {5'b00000, x, 3'b000};
  endfunction

  // low byte of the checksum over the four speeds and the trailer
  function automatic logic [7:0] speed_crc(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3);
    logic [15:0] crc;
    crc = crc_step(CrcSeed, b0);
    crc = crc_step(crc, b1);
    crc = crc_step(crc, b2);
    crc = crc_step(crc, b3);
    crc = crc_step(crc, SpeedTrailer);
    return crc[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/motor_bus_frame_sequencer.sv
// ----------------------------------------------------------------------------
// motor_bus_frame_sequencer: picks the next motor bus transfer per tick
// Speed, test, reverse and address assignment frames with a saturating
// count of failed and busy transfers.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the result is not stalled; the input
// register feeds the result register through one pass of decode and checksum logic
// reset: rst_ni clears the pending command, address step, serial bytes,
// motor indexes, error count, kill mode and both valid flags at once
`default_nettype none

module motor_bus_frame_sequencer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // kill mode register write
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] bus_status, [3:2] request, [5:4] new_address, [13:6] speed_front,
  // [21:14] speed_back, [29:22] speed_left, [37:30] speed_right,
  // [45:38] read_byte0, [53:46] read_byte1, [55:54] zero
  input  wire logic [mbfs_pkg::InDataW-1:0]  s_axis_tdata,
  // result items
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [6:0] bus_address, [9:7] transfer_length, [17:10] frame_byte0,
  // [25:18] frame_byte1, [33:26] frame_byte2, [41:34] frame_byte3,
  // [49:42] frame_byte4, [57:50] frame_byte5, [73:58] error_count, [79:74] zero
  output logic [mbfs_pkg::OutDataW-1:0]      m_axis_tdata,
  // [1:0] transfer_kind
  output logic [1:0]                         m_axis_tuser
);
  import mbfs_pkg::*;

  logic                in_valid_q;
  logic [InDataW-1:0]  in_data_q;
  logic                out_valid_q;
  result_t             out_q, out_d;
  logic                kill_q;
  logic [1:0]          pending_q, pending_d;
  logic [2:0]          step_q, step_d;
  logic [7:0]          serial_low_q, serial_low_d;
  logic [7:0]          serial_high_q, serial_high_d;
  logic [1:0]          current_q, current_d;
  logic [1:0]          target_q, target_d;
  logic [15:0]         fail_q, fail_d;
  logic                advance;

  logic [1:0] status, req, naddr;
  logic [7:0] spd_f, spd_b, spd_l, spd_r, rb0, rb1;

  assign status = in_data_q[1:0];
  assign req    = in_data_q[3:2];
  assign naddr  = in_data_q[5:4];
  assign spd_f  = in_data_q[13:6];
  assign spd_b  = in_data_q[21:14];
  assign spd_l  = in_data_q[29:22];
  assign spd_r  = in_data_q[37:30];
  assign rb0    = in_data_q[45:38];
  assign rb1    = in_data_q[53:46];

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    pending_d     = pending_q;
    step_d        = step_q;
    serial_low_d  = serial_low_q;
    serial_high_d = serial_high_q;
    current_d     = current_q;
    target_d      = target_q;
    fail_d        = fail_q;
    out_d         = '0;

    // a new request is taken only while nothing is pending
    if (req != CmdNone && pending_q == CmdNone) begin
      pending_d = req;
      if (req == CmdSetAddr) begin
        target_d = naddr;
      end
    end

    if ((status == StatusBusy || status == StatusFailed) && fail_q != 16'hFFFF) begin
      fail_d = fail_q + 16'd1;
    end

    if (status != StatusBusy) begin
      if (kill_q) begin
        out_d.transfer_kind   = XferWrite;
        out_d.bus_address     = WriteAddr;
        out_d.transfer_length = LenSpeed;
        out_d.frame_byte4     = SpeedTrailer;
        out_d.frame_byte5     = speed_crc(8'h00, 8'h00, 8'h00, 8'h00);
      end else begin
        unique case (pending_d)
          CmdTest: begin
            out_d.transfer_kind   = XferWrite;
            out_d.bus_address     = WriteAddr;
            out_d.transfer_length = LenShort;
            out_d.frame_byte0     = TestOpcode;
            out_d.frame_byte1     = {6'b000000, current_q};
            out_d.frame_byte3     = TestBase + {6'b000000, current_q};
            pending_d             = CmdNone;
          end
          CmdReverse: begin
            out_d.transfer_kind   = XferWrite;
            out_d.bus_address     = WriteAddr;
            out_d.transfer_length = LenShort;
            out_d.frame_byte0     = RevOpcode;
            out_d.frame_byte1     = {6'b000000, current_q};
            out_d.frame_byte3     = RevBase + {6'b000000, current_q};
            pending_d             = CmdNone;
          end
          CmdSetAddr: begin
            unique case (step_q)
              StepReadLow, StepReadHigh: begin
                out_d.transfer_kind   = XferRead;
                out_d.bus_address     = ReadAddrBase + {4'b0000, current_q, 1'b0};
                out_d.transfer_length = LenRead;
                step_d                = step_q + 3'd1;
              end
              StepCheckLow: begin
                if (rb0 == SerialLowTag) begin
                  serial_low_d = rb1;
                  step_d       = StepReadHigh;
                end else begin
                  step_d = StepReadLow;
                end
              end
              StepCheckHigh: begin
                if (rb0 == SerialHighTag) begin
                  serial_high_d = rb1;
                  step_d        = StepWriteAddress;
                end else begin
                  step_d = StepReadHigh;
                end
              end
              StepWriteAddress: begin
                out_d.transfer_kind   = XferWrite;
                out_d.bus_address     = WriteAddr;
                out_d.transfer_length = LenShort;
                out_d.frame_byte0     = {6'b000000, target_d};
                out_d.frame_byte1     = serial_low_q;
                out_d.frame_byte2     = serial_high_q;
                out_d.frame_byte3     = AddrOpcode;
                step_d                = StepReadLow;
                pending_d             = CmdNone;
                current_d             = target_d;
              end
              default: begin
                // stray step: abandon the assignment quietly
                step_d    = StepReadLow;
                pending_d = CmdNone;
                current_d = target_d;
              end
            endcase
          end
          default: begin
            out_d.transfer_kind   = XferWrite;
            out_d.bus_address     = WriteAddr;
            out_d.transfer_length = LenSpeed;
            out_d.frame_byte0     = spd_f;
            out_d.frame_byte1     = spd_b;
            out_d.frame_byte2     = spd_l;
            out_d.frame_byte3     = spd_r;
            out_d.frame_byte4     = SpeedTrailer;
            out_d.frame_byte5     = speed_crc(spd_f, spd_b, spd_l, spd_r);
          end
        endcase
      end
    end

    out_d.error_count = fail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      kill_q        <= 1'b0;
      pending_q     <= CmdNone;
      step_q        <= StepReadLow;
      serial_low_q  <= 8'h00;
      serial_high_q <= 8'h00;
      current_q     <= 2'd0;
      target_q      <= 2'd0;
      fail_q        <= 16'h0000;
    end else begin
      if (cfg_valid_i) begin
        kill_q <= cfg_data_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q   <= 1'b1;
        pending_q     <= pending_d;
        step_q        <= step_d;
        serial_low_q  <= serial_low_d;
        serial_high_q <= serial_high_d;
        current_q     <= current_d;
        target_q      <= target_d;
        fail_q        <= fail_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.transfer_kind;
  assign m_axis_tdata  = {6'b000000, out_q.error_count, out_q.frame_byte5,
                          out_q.frame_byte4, out_q.frame_byte3, out_q.frame_byte2,
                          out_q.frame_byte1, out_q.frame_byte0,
                          out_q.transfer_length, out_q.bus_address};

endmodule

`default_nettype wire

FILE: hdl/mbfs_checker.sv
// ----------------------------------------------------------------------------
// mbfs_checker: port checks for the motor bus frame sequencer
// Watches the result channel for well-formed transfers and a held payload.
// ----------------------------------------------------------------------------
`default_nettype none

module mbfs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [mbfs_pkg::OutDataW-1:0] m_axis_tdata,
  input wire logic [1:0]                    m_axis_tuser
);
  import mbfs_pkg::*;

  // a stalled result item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result item changed while stalled");

  // no transfer leaves address, length and frame bytes at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == XferNone |-> m_axis_tdata[57:0] == 58'd0)
    else $error("empty transfer carries data");

  // reads are three bytes at an odd-free motor address, with no frame bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == XferRead |->
      m_axis_tdata[9:7] == LenRead && m_axis_tdata[57:10] == 48'd0 &&
      m_axis_tdata[0] == 1'b0 && m_axis_tdata[6:4] == 3'd0)
    else $error("malformed read request");

  // writes go to address zero with a speed or short frame length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == XferWrite |->
      m_axis_tdata[6:0] == WriteAddr &&
      (m_axis_tdata[9:7] == LenSpeed || m_axis_tdata[9:7] == LenShort))
    else $error("malformed write frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser != 2'd3)
    else $error("unknown transfer kind");

endmodule

bind motor_bus_frame_sequencer mbfs_checker u_mbfs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
